// ===== rtl/stk_pkg.sv =====
// package: request/result types and constants for the space-time knn search
package stk_pkg;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [1:0] REG_NEIGHBOR_COUNT = 2'd0;
   localparam logic [1:0] REG_LIGHT_SPEED    = 2'd1;
   localparam logic [1:0] REG_TIMELIKE_GAIN  = 2'd2;

   localparam int DIST_W = 48;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] pos_a;
      logic signed [15:0] pos_b;
      logic signed [15:0] pos_c;
      logic signed [15:0] pos_time;
      logic [31:0]        point_id;
   } req_type;

   typedef struct packed {
      logic [31:0] query_id;
      logic [31:0] neighbor_id;
      logic        valid_res;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/spacetime_knn_topk.sv =====
// top level: brute-force space-time k-nearest-neighbour search over a point memory
//
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_data (stk_pkg::req_type)
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data (stk_pkg::rsp_type)
//  csr     | in        | csr_write, csr_index, csr_data
//
// a query scans every loaded point (one point read from the coordinate memory per
// cycle through a six-stage distance pipeline), then for each result reads the id
// memory and presents it.
// reset is synchronous and clears the point count, registers and control only.
// a stalled result holds in the output register; requests wait while a query runs.
module spacetime_knn_topk #(
   parameter int MAX_POINTS    = 1024,
   parameter int MAX_NEIGHBORS = 16,
   parameter int SPACE_DIMS    = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stk_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stk_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int KW = $clog2(MAX_NEIGHBORS);
   localparam int NW = $clog2(MAX_NEIGHBORS + 1);
   localparam int DW = stk_pkg::DIST_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_READ = 2'd3;

   // configuration registers
   logic [4:0]  count_ff;
   logic [15:0] speed_ff, gain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd16;
         speed_ff <= 16'd256;
         gain_ff  <= 16'd256;
      end else if (csr_write) begin
         case (csr_index)
            stk_pkg::REG_NEIGHBOR_COUNT: count_ff <= csr_data[4:0];
            stk_pkg::REG_LIGHT_SPEED:    speed_ff <= csr_data;
            stk_pkg::REG_TIMELIKE_GAIN:  gain_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective k, clamped to 1..MAX_NEIGHBORS
   logic [NW-1:0] k_eff;
   always_comb begin
      if (count_ff == 5'd0) k_eff = NW'(1);
      else if (32'(count_ff) > MAX_NEIGHBORS) k_eff = NW'(MAX_NEIGHBORS);
      else k_eff = NW'(count_ff);
   end

   // control state
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] total_ff;
   logic [CW-1:0] addr_ff;
   logic [NW-1:0] emit_ff;
   logic [NW-1:0] nfill;
   logic [31:0]   qid_ff;
   logic signed [15:0] qa_ff, qb_ff, qc_ff, qt_ff;
   logic [2:0]    drain_ff;

   logic req_acc;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   // point memories
   logic [63:0] coord_mem [MAX_POINTS];
   logic [31:0] id_mem [MAX_POINTS];
   logic [63:0] coord_rd_ff;
   logic [31:0] id_rd_ff;
   logic [AW-1:0] id_addr;
   logic wr_en;
   assign wr_en = req_acc && req_data.action == stk_pkg::ACT_LOAD &&
                  32'(total_ff) < MAX_POINTS;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_mem[total_ff[AW-1:0]] <= {req_data.pos_time, req_data.pos_c,
                                         req_data.pos_b, req_data.pos_a};
         id_mem[total_ff[AW-1:0]] <= req_data.point_id;
      end
      coord_rd_ff <= coord_mem[addr_ff[AW-1:0]];
      id_rd_ff    <= id_mem[id_addr];
   end

   // scan valid pipeline: stage 0 is memory read
   logic scan_issue;
   assign scan_issue = (state_ff == ST_SCAN) && (addr_ff < total_ff);
   logic [5:0]    pv_ff;
   logic [AW-1:0] ps0_ff, ps1_ff, ps2_ff, ps3_ff, ps4_ff, ps5_ff;

   // stage 1: differences
   logic [16:0] d0_ff, d1_ff, d2_ff, dt_ff;
   function automatic logic [16:0] absd(input logic signed [15:0] p,
                                       input logic signed [15:0] q);
      logic signed [16:0] d;
      d = 17'(p) - 17'(q);
      return d[16] ? 17'(-d) : d;
   endfunction

   // stage 2: squares and time product
   logic [33:0] sq0_ff, sq1_ff, sq2_ff;
   logic [32:0] lt_ff;
   // stage 3: spatial sum, time square
   logic [35:0] s_ff;
   logic [65:0] t_ff;
   // stage 4: compare/subtract
   logic [66:0] s32;
   logic        pos_ff;
   logic [50:0] m_ff;
   // stage 5: gain (timelike points only) and saturate
   logic [DW-1:0] dist_ff;
   logic [66:0]   gm;

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= '0;
      else pv_ff <= {pv_ff[4:0], scan_issue};
      ps0_ff <= addr_ff[AW-1:0];
      ps1_ff <= ps0_ff; ps2_ff <= ps1_ff; ps3_ff <= ps2_ff;
      ps4_ff <= ps3_ff; ps5_ff <= ps4_ff;
      d0_ff <= absd(coord_rd_ff[15:0], qa_ff);
      d1_ff <= (SPACE_DIMS > 1) ? absd(coord_rd_ff[31:16], qb_ff) : 17'd0;
      d2_ff <= (SPACE_DIMS > 2) ? absd(coord_rd_ff[47:32], qc_ff) : 17'd0;
      dt_ff <= absd(coord_rd_ff[63:48], qt_ff);
      sq0_ff <= d0_ff * d0_ff;
      sq1_ff <= d1_ff * d1_ff;
      sq2_ff <= d2_ff * d2_ff;
      lt_ff  <= speed_ff * dt_ff;
      s_ff   <= 36'(sq0_ff) + 36'(sq1_ff) + 36'(sq2_ff);
      t_ff   <= lt_ff * lt_ff;
      pos_ff <= s32 >= 67'(t_ff);
      m_ff   <= s32 >= 67'(t_ff) ? 51'((s32 - 67'(t_ff)) >> 16)
                                 : 51'((67'(t_ff) - s32) >> 16);
      if (pos_ff)
         dist_ff <= (m_ff > 51'(stk_pkg::DIST_MAX)) ? stk_pkg::DIST_MAX : m_ff[DW-1:0];
      else
         dist_ff <= (gm[66:8] > 59'(stk_pkg::DIST_MAX)) ? stk_pkg::DIST_MAX : gm[DW+7:8];
   end
   assign s32 = {15'd0, s_ff, 16'd0};
   assign gm  = 67'(m_ff) * 67'(gain_ff);

   // sorted top-k list in registers, one insertion per cycle
   logic [DW-1:0] bd_ff [MAX_NEIGHBORS];
   logic [AW-1:0] bs_ff [MAX_NEIGHBORS];
   logic [MAX_NEIGHBORS-1:0] bf_ff;
   logic [MAX_NEIGHBORS-1:0] hit;

   always_comb begin
      for (int e = 0; e < MAX_NEIGHBORS; e++)
         hit[e] = (e < k_eff) && (!bf_ff[e] || dist_ff < bd_ff[e]);
   end

   always_ff @(posedge clock) begin
      if (reset || (req_acc && req_data.action == stk_pkg::ACT_QUERY)) begin
         bf_ff <= '0;
      end else if (pv_ff[5] && |hit) begin
         for (int e = 0; e < MAX_NEIGHBORS; e++) begin
            if (hit[e] && (e == 0 || !hit[e-1 < 0 ? 0 : e-1])) begin
               bd_ff[e] <= dist_ff;
               bs_ff[e] <= ps5_ff;
               bf_ff[e] <= 1'b1;
            end else if (e > 0 && hit[e-1 < 0 ? 0 : e-1] && e < k_eff) begin
               bd_ff[e] <= bd_ff[e-1];
               bs_ff[e] <= bs_ff[e-1];
               bf_ff[e] <= bf_ff[e-1];
            end
         end
      end
   end

   always_comb begin
      nfill = '0;
      for (int e = 0; e < MAX_NEIGHBORS; e++)
         nfill = nfill + NW'(bf_ff[e]);
   end
   assign id_addr = bs_ff[emit_ff[KW > 0 ? KW-1 : 0:0]];

   // sequencer
   logic rsp_free;
   assign rsp_free = !rsp_valid || !rsp_stall;
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_acc && req_data.action == stk_pkg::ACT_QUERY) state_in = ST_SCAN;
         ST_SCAN: if (!scan_issue && pv_ff == '0 && drain_ff == 3'd7) state_in = ST_READ;
         ST_READ: if (rsp_free) state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               if (nfill != '0 && emit_ff + 1'b1 != nfill) state_in = ST_READ;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         total_ff  <= '0;
         addr_ff   <= '0;
         emit_ff   <= '0;
         drain_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc) begin
            case (req_data.action)
               stk_pkg::ACT_CLEAR: total_ff <= '0;
               stk_pkg::ACT_LOAD:  if (wr_en) total_ff <= total_ff + 1'b1;
               stk_pkg::ACT_QUERY: begin
                  addr_ff  <= '0;
                  emit_ff  <= '0;
                  drain_ff <= '0;
                  qid_ff   <= req_data.point_id;
                  qa_ff    <= req_data.pos_a;
                  qb_ff    <= req_data.pos_b;
                  qc_ff    <= req_data.pos_c;
                  qt_ff    <= req_data.pos_time;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_SCAN) begin
            if (scan_issue) addr_ff <= addr_ff + 1'b1;
            else if (drain_ff != 3'd7) drain_ff <= drain_ff + 1'b1;
         end
         // emit: READ lets the id memory read register, EMIT presents the result
         if (state_ff == ST_EMIT && rsp_free) begin
            rsp_valid            <= 1'b1;
            rsp_data.query_id    <= qid_ff;
            rsp_data.neighbor_id <= (nfill == '0) ? 32'd0 : id_rd_ff;
            rsp_data.valid_res   <= (nfill != '0);
            rsp_data.last        <= (nfill == '0) || (emit_ff + 1'b1 == nfill);
            if (nfill != '0 && emit_ff + 1'b1 != nfill) emit_ff <= emit_ff + 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

endmodule
